[src/assert_macros.svh]
// assertion macros shared by the fragmenter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// delayed implication
`define MF_ASSERT_D2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

[src/mfrag_pkg.sv]
// types and constants of the message fragmenter
`default_nettype none
package mfrag_pkg;

    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 19;
    localparam int ID_IN_W          = 40;
    localparam int ID_IN_BYTES      = ID_IN_W / BYTE_W;
    localparam int BODY_W           = 11;
    localparam int MAX_FRAGS        = 255;
    localparam int S_TDATA_W        = 72;
    localparam int DEFAULT_BODY_MAX = 1462;
    localparam int DEFAULT_ID_BYTES = 5;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_TOO_LONG = 2'd1,
        STAT_NO_MSG   = 2'd2
    } t_status;

    typedef struct packed {
        logic              lead_vld;
        logic [BYTE_W-1:0] lead_byte;
        logic              lead_flast;
        t_status           lead_status;
        logic              hdr_vld;
        logic [BYTE_W-1:0] hdr_index;
        logic [BYTE_W-1:0] hdr_count;
        logic [BODY_W-1:0] hdr_len;
    } t_job;

    typedef struct packed {
        logic ready;
        logic busy;
    } t_emit_stat;

endpackage
`default_nettype wire

[src/mfrag_ctrl.sv]
// message state and per-beat job build for the fragmenter
`default_nettype none
module mfrag_ctrl
    import mfrag_pkg::*;
#(
    parameter int BODY_MAX = DEFAULT_BODY_MAX,
    parameter int ID_BYTES = DEFAULT_ID_BYTES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_acc,
    input  wire logic                    i_command,
    input  wire logic [LEN_W-1:0]        i_length,
    input  wire logic [ID_IN_W-1:0]      i_id,
    input  wire logic [BYTE_W-1:0]       i_data,
    output logic                         o_job_vld,
    output t_job                         o_job,
    output logic [ID_BYTES*BYTE_W-1:0]   o_id
);

    localparam int ID_W  = ID_BYTES * BYTE_W;
    localparam int SH    = LEN_W + $clog2(BODY_MAX);
    localparam int MUL_W = SH + 1;
    localparam int PRD_W = LEN_W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SH) + 64'(BODY_MAX) - 64'd1) / 64'(BODY_MAX));
    localparam logic [LEN_W-1:0]  LEN_LIMIT = LEN_W'(MAX_FRAGS * BODY_MAX);
    localparam logic [BODY_W-1:0] BODY_LIM  = BODY_W'(BODY_MAX);

    logic              r_active,   n_active;
    logic [LEN_W-1:0]  r_total,    n_total;
    logic [BODY_W-1:0] r_body,     n_body;
    logic [BYTE_W-1:0] r_index,    n_index;
    logic [BYTE_W-1:0] r_count,    n_count;
    logic [ID_W-1:0]   r_id,       n_id;

    logic [ID_W-1:0]   w_id_in;
    logic [LEN_W-1:0]  w_len_m1;
    logic [PRD_W-1:0]  w_prod;
    logic [BYTE_W-1:0] w_cnt;
    logic [BODY_W-1:0] w_body_dec;
    logic [LEN_W-1:0]  w_total_dec;

    function automatic logic [BODY_W-1:0] min_body(input logic [LEN_W-1:0] left);
        min_body = (left < LEN_W'(BODY_MAX)) ? left[BODY_W-1:0] : BODY_LIM;
    endfunction

    for (genvar g = 0; g < ID_BYTES; g++) begin : g_id
        if (g < ID_IN_BYTES) begin : g_src
            assign w_id_in[g*BYTE_W +: BYTE_W] = i_id[g*BYTE_W +: BYTE_W];
        end else begin : g_zero
            assign w_id_in[g*BYTE_W +: BYTE_W] = '0;
        end
    end

    // fragment count by reciprocal multiply
    assign w_len_m1 = i_length - LEN_W'(1);
    assign w_prod   = PRD_W'(w_len_m1) * PRD_W'(RECIP);
    assign w_cnt    = w_prod[SH +: BYTE_W] + BYTE_W'(1);

    assign w_body_dec  = (r_body  != '0) ? r_body  - BODY_W'(1) : r_body;
    assign w_total_dec = (r_total != '0) ? r_total - LEN_W'(1)  : r_total;

    always_comb begin
        n_active  = r_active;
        n_total   = r_total;
        n_body    = r_body;
        n_index   = r_index;
        n_count   = r_count;
        n_id      = r_id;
        o_job_vld = 1'b0;
        o_job     = '0;
        if (i_acc) begin
            if (!i_command) begin
                n_active = 1'b0;
                if (i_length == '0) begin
                    o_job_vld = 1'b0;
                end else if (i_length > LEN_LIMIT) begin
                    o_job_vld          = 1'b1;
                    o_job.lead_vld     = 1'b1;
                    o_job.lead_status  = STAT_TOO_LONG;
                end else begin
                    n_active        = 1'b1;
                    n_id            = w_id_in;
                    n_total         = i_length;
                    n_index         = '0;
                    n_count         = w_cnt;
                    n_body          = min_body(i_length);
                    o_job_vld       = 1'b1;
                    o_job.hdr_vld   = 1'b1;
                    o_job.hdr_index = '0;
                    o_job.hdr_count = w_cnt;
                    o_job.hdr_len   = min_body(i_length);
                end
            end else if (!r_active) begin
                o_job_vld         = 1'b1;
                o_job.lead_vld    = 1'b1;
                o_job.lead_status = STAT_NO_MSG;
            end else begin
                n_body            = w_body_dec;
                n_total           = w_total_dec;
                o_job_vld         = 1'b1;
                o_job.lead_vld    = 1'b1;
                o_job.lead_byte   = i_data;
                o_job.lead_flast  = (w_body_dec == '0);
                o_job.lead_status = STAT_OK;
                if (w_body_dec == '0) begin
                    if (w_total_dec != '0) begin
                        n_index         = r_index + BYTE_W'(1);
                        n_body          = min_body(w_total_dec);
                        o_job.hdr_vld   = 1'b1;
                        o_job.hdr_index = r_index + BYTE_W'(1);
                        o_job.hdr_count = r_count;
                        o_job.hdr_len   = min_body(w_total_dec);
                    end else begin
                        n_active = 1'b0;
                    end
                end
            end
        end
    end

    assign o_id = n_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_total  <= '0;
            r_body   <= '0;
            r_index  <= '0;
            r_count  <= '0;
            r_id     <= '0;
        end else begin
            r_active <= n_active;
            r_total  <= n_total;
            r_body   <= n_body;
            r_index  <= n_index;
            r_count  <= n_count;
            r_id     <= n_id;
        end
    end

endmodule
`default_nettype wire

[src/mfrag_emit.sv]
// job register, header serialiser and output register
`default_nettype none
module mfrag_emit
    import mfrag_pkg::*;
#(
    parameter int ID_BYTES = DEFAULT_ID_BYTES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_job_vld,
    input  wire t_job                        i_job,
    input  wire logic [ID_BYTES*BYTE_W-1:0]  i_id,
    output t_emit_stat                       o_stat,
    output logic                             o_vld,
    input  wire logic                        i_rdy,
    output logic [BYTE_W-1:0]                o_byte,
    output logic                             o_flast,
    output logic                             o_run_last,
    output t_status                          o_status
);

    localparam int ID_W    = ID_BYTES * BYTE_W;
    localparam int HDR_LEN = ID_BYTES + 5;
    localparam int POS_W   = $clog2(HDR_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_LEN - 1);

    t_job              r_job;
    logic [ID_W-1:0]   r_id;
    logic              r_job_vld;
    logic              r_lead_pend;
    logic [POS_W-1:0]  r_pos;

    logic              r_o_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              r_flast;
    logic              r_run_last;
    t_status           r_status;

    logic [BYTE_W-1:0] w_hdr [HDR_LEN];
    logic [BYTE_W-1:0] w_sum;
    logic              w_out_load;
    logic              w_go;
    logic              w_last;
    logic              w_take;
    logic [BYTE_W-1:0] w_byte;
    logic              w_flast;
    t_status           w_status;

    always_comb begin
        w_sum = r_job.hdr_index ^ r_job.hdr_count ^ r_job.hdr_len[BYTE_W-1:0]
              ^ BYTE_W'(r_job.hdr_len[BODY_W-1:BYTE_W]);
        for (int i = 0; i < ID_BYTES; i++) begin
            w_hdr[i] = r_id[i*BYTE_W +: BYTE_W];
            w_sum    = w_sum ^ r_id[i*BYTE_W +: BYTE_W];
        end
        w_hdr[ID_BYTES]     = r_job.hdr_index;
        w_hdr[ID_BYTES + 1] = r_job.hdr_count;
        w_hdr[ID_BYTES + 2] = r_job.hdr_len[BYTE_W-1:0];
        w_hdr[ID_BYTES + 3] = BYTE_W'(r_job.hdr_len[BODY_W-1:BYTE_W]);
        w_hdr[ID_BYTES + 4] = w_sum;
    end

    assign w_out_load = !r_o_vld || i_rdy;
    assign w_go       = r_job_vld && w_out_load;
    assign w_last     = r_lead_pend ? !r_job.hdr_vld : (r_pos == POS_LAST);
    assign w_take     = !r_job_vld || (w_go && w_last);

    assign w_byte   = r_lead_pend ? r_job.lead_byte   : w_hdr[r_pos];
    assign w_flast  = r_lead_pend ? r_job.lead_flast  : 1'b0;
    assign w_status = r_lead_pend ? r_job.lead_status : STAT_OK;

    assign o_stat.ready = w_take;
    assign o_stat.busy  = r_job_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld   <= 1'b0;
            r_lead_pend <= 1'b0;
            r_pos       <= '0;
            r_o_vld     <= 1'b0;
        end else begin
            if (w_take && i_job_vld) begin
                r_job_vld   <= 1'b1;
                r_lead_pend <= i_job.lead_vld;
                r_pos       <= '0;
            end else if (w_go && w_last) begin
                r_job_vld <= 1'b0;
            end else if (w_go) begin
                if (r_lead_pend) begin
                    r_lead_pend <= 1'b0;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (w_out_load) begin
                r_o_vld <= w_go;
            end
        end
        if (w_take && i_job_vld) begin
            r_job <= i_job;
            r_id  <= i_id;
        end
        if (w_go) begin
            r_byte     <= w_byte;
            r_flast    <= w_flast;
            r_run_last <= w_last;
            r_status   <= w_status;
        end
    end

    assign o_vld      = r_o_vld;
    assign o_byte     = r_byte;
    assign o_flast    = r_flast;
    assign o_run_last = r_run_last;
    assign o_status   = r_status;

endmodule
`default_nettype wire

[src/message_fragmenter.sv]
// top level of the message fragmenter
//
// channel  dir  tdata                                   tuser                 tlast
// s        in   msg_length[18:0] msg_id[58:19]          command               -
//               data_byte[66:59] zero[71:67]
// m        out  out_byte[7:0]                           run_last[0]           fragment_last
//                                                       status[2:1]
//
// one item per cycle unless extra beats are pending or the output stalls; a start gives
// ID_BYTES+5 header beats, a data beat closing a non-final fragment its byte and the header
// an item's first output beat passes through the job register, then the output register
// synchronous active-low reset clears message state and both valid flags
// downstream stalls hold the output register and back up through the job register
`default_nettype none
`include "assert_macros.svh"
module message_fragmenter
    import mfrag_pkg::*;
#(
    parameter int BODY_MAX = DEFAULT_BODY_MAX,
    parameter int ID_BYTES = DEFAULT_ID_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // msg_length, msg_id, data_byte, zero pad
    input  wire logic                 i_s_tuser,  // command
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [BYTE_W-1:0]         o_m_tdata,  // out_byte
    output logic                      o_m_tlast,
    output logic [2:0]                o_m_tuser   // run_last, status
);

    localparam int ID_LO   = LEN_W;
    localparam int DATA_LO = LEN_W + ID_IN_W;

    t_emit_stat                 w_stat;
    logic                       w_acc;
    logic                       w_job_vld;
    t_job                       w_job;
    logic [ID_BYTES*BYTE_W-1:0] w_id;
    logic                       w_run_last;
    t_status                    w_status;

    assign w_acc      = i_s_tvalid && w_stat.ready;
    assign o_s_tready = w_stat.ready;

    mfrag_ctrl #(
        .BODY_MAX (BODY_MAX),
        .ID_BYTES (ID_BYTES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc),
        .i_command (i_s_tuser),
        .i_length  (i_s_tdata[LEN_W-1:0]),
        .i_id      (i_s_tdata[ID_LO +: ID_IN_W]),
        .i_data    (i_s_tdata[DATA_LO +: BYTE_W]),
        .o_job_vld (w_job_vld),
        .o_job     (w_job),
        .o_id      (w_id)
    );

    mfrag_emit #(
        .ID_BYTES (ID_BYTES)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_vld  (w_job_vld),
        .i_job      (w_job),
        .i_id       (w_id),
        .o_stat     (w_stat),
        .o_vld      (o_m_tvalid),
        .i_rdy      (i_m_tready),
        .o_byte     (o_m_tdata),
        .o_flast    (o_m_tlast),
        .o_run_last (w_run_last),
        .o_status   (w_status)
    );

    assign o_m_tuser = {w_status, w_run_last};

    `MF_ASSERT_IMP(a_err_beat, o_m_tvalid && (w_status != STAT_OK), w_run_last && !o_m_tlast && (o_m_tdata == '0), "error beat malformed")
    `MF_ASSERT_IMP(a_stat_code, o_m_tvalid, (w_status == STAT_OK) || (w_status == STAT_TOO_LONG) || (w_status == STAT_NO_MSG), "bad status code")
    `MF_ASSERT_IMP(a_full_stall, o_m_tvalid && !i_m_tready && w_stat.busy, !o_s_tready, "item taken while pipeline full")
    `MF_ASSERT_D2(a_data_out, w_acc && i_s_tuser && !w_stat.busy && !o_m_tvalid, o_m_tvalid, "data beat gave no output")

endmodule
`default_nettype wire
